[src/btas_pkg.sv]
// ----------------------------------------------------------------------------
// btas_pkg: shared types and constants of the block transfer address sequencer
// Instruction field positions, result kinds and the address unit command set.
// ----------------------------------------------------------------------------
`default_nettype none

package btas_pkg;

    // sizes
    localparam int NUM_REGS_DEF = 16;
    localparam int MAX_REGS     = 16;
    localparam int REG_W        = 4;
    localparam int WORD_W       = 32;
    localparam int CNT_W        = 5;
    localparam int WORD_BYTES   = 4;

    // instruction word bit positions
    localparam int BIT_PRE  = 24;
    localparam int BIT_UP   = 23;
    localparam int BIT_USER = 22;
    localparam int BIT_WB   = 21;
    localparam int BIT_LOAD = 20;
    localparam int RN_LSB   = 16;

    // result kinds
    localparam logic [1:0] KIND_XFER = 2'd0;
    localparam logic [1:0] KIND_WB   = 2'd1;
    localparam logic [1:0] KIND_USER = 2'd2;

    // address unit operations
    typedef enum logic [2:0] {
        AGU_HOLD,
        AGU_LOAD,
        AGU_NEWBASE,
        AGU_START,
        AGU_STEP
    } agu_op_t;

    typedef struct packed {
        agu_op_t op;
        logic    up;
        logic    pre;
    } agu_cmd_t;

    // number of set bits in a register list
    function automatic logic [CNT_W-1:0] list_count(input logic [MAX_REGS-1:0] list);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAX_REGS; i++) begin
            n = n + CNT_W'(list[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[src/block_transfer_address_sequencer.sv]
// sequence: after the input transfer the sequencer passes S_NEWBASE and S_START
//   before the first result enters the output register; a user-bank error goes via S_ERR
// throughput: one result per cycle while the receiver accepts; a new instruction is
//   taken only in idle, after the last result of the previous one is registered
// reset: aresetn (synchronous, active low) returns the sequencer to idle and
//   empties the output register
// ----------------------------------------------------------------------------
// block_transfer_address_sequencer: load/store-multiple address sequencer
// Takes an instruction word and base value and emits one transfer per listed
// register, lowest first, plus the base writeback when requested; a user-bank form gives one error result.
// ----------------------------------------------------------------------------
`default_nettype none

module block_transfer_address_sequencer #(
    parameter int NUM_REGS = btas_pkg::NUM_REGS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // instruction[31:0], base_value[63:32]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // is_load[0], reg_index[4:1], address[36:5], zero
    output logic [1:0]       m_axis_tuser,  // kind[1:0]
    output logic             m_axis_tlast   // last
);
    import btas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_NEWBASE,
        S_START,
        S_PRE_WB,
        S_XFER,
        S_POST_WB
    } state_t;

    state_t               state_reg, state_next;
    logic                 up_reg, up_next;
    logic                 pre_reg, pre_next;
    logic                 wb_reg, wb_next;
    logic                 load_reg, load_next;
    logic [REG_W-1:0]     rn_reg, rn_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_REGS-1:0]  list_reg, list_next;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_kind_reg, m_kind_next;
    logic                 m_load_reg, m_load_next;
    logic [REG_W-1:0]     m_idx_reg, m_idx_next;
    logic [WORD_W-1:0]    m_addr_reg, m_addr_next;
    logic                 m_last_reg, m_last_next;

    logic [WORD_W-1:0]    instr;
    logic [WORD_W-1:0]    base_in;
    logic [NUM_REGS-1:0]  list_in;
    logic [NUM_REGS-1:0]  list_clr;
    logic [REG_W-1:0]     low_idx;
    logic                 out_free;
    agu_cmd_t             agu_cmd;
    logic [WORD_W-1:0]    agu_addr;
    logic [WORD_W-1:0]    agu_nb;

    assign instr   = s_axis_tdata[31:0];
    assign base_in = s_axis_tdata[63:32];
    assign list_in = instr[NUM_REGS-1:0];

    // lowest listed register and the list without it
    always_comb begin
        low_idx = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (list_reg[i]) begin
                low_idx = REG_W'(i);
            end
        end
    end

    assign list_clr = list_reg & (list_reg - NUM_REGS'(1));
    assign out_free = ~m_valid_reg | m_axis_tready;

    // shared address unit
    btas_agu u_agu (
        .aclk     (aclk),
        .cmd      (agu_cmd),
        .base_in  (base_in),
        .count    (count_reg),
        .addr     (agu_addr),
        .new_base (agu_nb)
    );

    // sequencer next state
    always_comb begin
        state_next   = state_reg;
        up_next      = up_reg;
        pre_next     = pre_reg;
        wb_next      = wb_reg;
        load_next    = load_reg;
        rn_next      = rn_reg;
        count_next   = count_reg;
        list_next    = list_reg;
        m_valid_next = m_valid_reg & ~m_axis_tready;
        m_kind_next  = m_kind_reg;
        m_load_next  = m_load_reg;
        m_idx_next   = m_idx_reg;
        m_addr_next  = m_addr_reg;
        m_last_next  = m_last_reg;
        agu_cmd.op   = AGU_HOLD;
        agu_cmd.up   = up_reg;
        agu_cmd.pre  = pre_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    pre_next   = instr[BIT_PRE];
                    up_next    = instr[BIT_UP];
                    wb_next    = instr[BIT_WB];
                    load_next  = instr[BIT_LOAD];
                    rn_next    = instr[RN_LSB +: REG_W];
                    list_next  = list_in;
                    count_next = list_count(MAX_REGS'(list_in));
                    agu_cmd.op = AGU_LOAD;
                    state_next = instr[BIT_USER] ? S_ERR : S_NEWBASE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_USER;
                    m_load_next  = load_reg;
                    m_idx_next   = rn_reg;
                    m_addr_next  = '0;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_NEWBASE: begin
                agu_cmd.op = AGU_NEWBASE;
                state_next = S_START;
            end
            S_START: begin
                agu_cmd.op = AGU_START;
                if (!up_reg && wb_reg) begin
                    state_next = S_PRE_WB;
                end else if (list_reg != '0) begin
                    state_next = S_XFER;
                end else if (wb_reg) begin
                    state_next = S_POST_WB;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PRE_WB: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_WB;
                    m_load_next  = load_reg;
                    m_idx_next   = rn_reg;
                    m_addr_next  = agu_nb;
                    m_last_next  = (list_reg == '0);
                    state_next   = (list_reg != '0) ? S_XFER : S_IDLE;
                end
            end
            S_XFER: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_XFER;
                    m_load_next  = load_reg;
                    m_idx_next   = low_idx;
                    m_addr_next  = agu_addr;
                    m_last_next  = (list_clr == '0) && !(up_reg && wb_reg);
                    list_next    = list_clr;
                    agu_cmd.op   = AGU_STEP;
                    if (list_clr == '0) begin
                        state_next = (up_reg && wb_reg) ? S_POST_WB : S_IDLE;
                    end
                end
            end
            S_POST_WB: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_WB;
                    m_load_next  = load_reg;
                    m_idx_next   = rn_reg;
                    m_addr_next  = agu_nb;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        up_reg     <= up_next;
        pre_reg    <= pre_next;
        wb_reg     <= wb_next;
        load_reg   <= load_next;
        rn_reg     <= rn_next;
        count_reg  <= count_next;
        list_reg   <= list_next;
        m_kind_reg <= m_kind_next;
        m_load_reg <= m_load_next;
        m_idx_reg  <= m_idx_next;
        m_addr_reg <= m_addr_next;
        m_last_reg <= m_last_next;
    end

    // port drive
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_addr_reg, m_idx_reg, m_load_reg};
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

[src/btas_agu.sv]
// ----------------------------------------------------------------------------
// btas_agu: address unit of the block transfer sequencer
// One shared 32-bit adder computes the new base, the start address and each
// following word address under commands from the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module btas_agu (
    input  wire logic                         aclk,
    input  wire btas_pkg::agu_cmd_t           cmd,
    input  wire logic [btas_pkg::WORD_W-1:0]  base_in,
    input  wire logic [btas_pkg::CNT_W-1:0]   count,
    output logic      [btas_pkg::WORD_W-1:0]  addr,
    output logic      [btas_pkg::WORD_W-1:0]  new_base
);
    import btas_pkg::*;

    logic [WORD_W-1:0] base_reg;
    logic [WORD_W-1:0] nb_reg;
    logic [WORD_W-1:0] addr_reg;
    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] op_b;
    logic              sub;
    logic [WORD_W-1:0] sum;

    // operand selection for the shared adder
    always_comb begin
        op_a = addr_reg;
        op_b = '0;
        sub  = 1'b0;
        case (cmd.op)
            AGU_NEWBASE: begin
                op_a = base_reg;
                op_b = {{(WORD_W-CNT_W-2){1'b0}}, count, 2'b00};
                sub  = ~cmd.up;
            end
            AGU_START: begin
                op_a = cmd.up ? base_reg : nb_reg;
                op_b = (cmd.up == cmd.pre) ? WORD_W'(WORD_BYTES) : '0;
            end
            AGU_STEP: begin
                op_b = WORD_W'(WORD_BYTES);
            end
            default: begin
                op_b = '0;
            end
        endcase
    end

    // add or subtract, wrapping at 32 bits
    assign sum = op_a + (sub ? ~op_b : op_b) + {{(WORD_W-1){1'b0}}, sub};

    // datapath registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            AGU_LOAD:    base_reg <= base_in;
            AGU_NEWBASE: nb_reg   <= sum;
            AGU_START:   addr_reg <= sum;
            AGU_STEP:    addr_reg <= sum;
            default:     addr_reg <= addr_reg;
        endcase
    end

    assign addr     = addr_reg;
    assign new_base = nb_reg;

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the block transfer address sequencer
// Drives load/store-multiple instructions with base values and checks every
// emitted transfer, writeback and error result, in order, against a behavioral predictor.
// ----------------------------------------------------------------------------

module tb;
    import btas_pkg::*;

    localparam int LIST_MASK   = (1 << NUM_REGS_DEF) - 1;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 400;
    localparam int WDOG_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 40;
    localparam int RAND_ITEMS  = 500;

    // one predicted or observed result
    typedef struct packed {
        logic [1:0]  kind;
        logic        is_load;
        logic [3:0]  reg_idx;
        logic [31:0] address;
        logic        last;
    } access_t;

    // expected access sequence per accepted instruction
    class ldm_scoreboard;
        access_t     pending_q[$];
        int          errors;
        int unsigned emitted;
        int unsigned total;

        function new();
            errors = 0;
        endfunction

        function void push_access(logic [1:0] kind, logic ld, logic [3:0] ridx,
                                  logic [31:0] addr);
            access_t a;
            emitted++;
            a.kind    = kind;
            a.is_load = ld;
            a.reg_idx = ridx;
            a.address = addr;
            a.last    = (emitted == total);
            pending_q.push_back(a);
        endfunction

        // expand one accepted instruction into its access sequence
        function void note_instruction(logic [31:0] insn, logic [31:0] base);
            logic        pre, up, user, wb, ld;
            logic [3:0]  rn;
            logic [15:0] list;
            logic [31:0] cnt;
            logic [31:0] addr;
            logic [31:0] nbase;
            pre  = insn[BIT_PRE];
            up   = insn[BIT_UP];
            user = insn[BIT_USER];
            wb   = insn[BIT_WB];
            ld   = insn[BIT_LOAD];
            rn   = insn[RN_LSB +: REG_W];
            list = insn[15:0] & LIST_MASK[15:0];
            emitted = 0;

            // user-bank form: single error result
            if (user) begin
                total = 1;
                push_access(KIND_USER, ld, rn, 32'd0);
                return;
            end

            cnt = 0;
            for (int i = 0; i < MAX_REGS; i++)
                cnt = cnt + {31'd0, list[i]};
            total = cnt + (wb ? 1 : 0);

            if (up) begin
                nbase = base + WORD_BYTES * cnt;
                addr  = pre ? base + WORD_BYTES : base;
            end else begin
                nbase = base - WORD_BYTES * cnt;
                addr  = pre ? nbase : nbase + WORD_BYTES;
                if (wb)
                    push_access(KIND_WB, ld, rn, nbase);
            end

            for (int i = 0; i < MAX_REGS; i++) begin
                if (list[i]) begin
                    push_access(KIND_XFER, ld, i[3:0], addr);
                    addr = addr + WORD_BYTES;
                end
            end

            if (up && wb)
                push_access(KIND_WB, ld, rn, nbase);
        endfunction

        // compare one observed result with the oldest expected one
        function void check_access(access_t got);
            access_t want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d reg=%0d addr=%h last=%0d",
                         $time, got.kind, got.reg_idx, got.address, got.last);
                return;
            end
            want = pending_q.pop_front();
            if (got.kind !== want.kind) begin
                errors++;
                $display("%0t: kind mismatch expected %0d actual %0d",
                         $time, want.kind, got.kind);
            end
            if (got.is_load !== want.is_load) begin
                errors++;
                $display("%0t: is_load mismatch expected %0d actual %0d",
                         $time, want.is_load, got.is_load);
            end
            if (got.reg_idx !== want.reg_idx) begin
                errors++;
                $display("%0t: reg_index mismatch expected %0d actual %0d",
                         $time, want.reg_idx, got.reg_idx);
            end
            if (got.address !== want.address) begin
                errors++;
                $display("%0t: address mismatch expected %h actual %h",
                         $time, want.address, got.address);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last mismatch expected %0d actual %0d",
                         $time, want.last, got.last);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic        steady  = 1'b0;   // no idling on either side
    logic        hold_go = 1'b0;   // request the long receiver hold-off
    logic        hold_done = 1'b0;
    int          hold_cnt  = 0;
    int          quiet_cycles = 0;

    ldm_scoreboard sb = new();

    block_transfer_address_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: random stalls, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done     <= 1'b1;
            hold_cnt      <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        access_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.kind    = m_axis_tuser;
            got.is_load = m_axis_tdata[0];
            got.reg_idx = m_axis_tdata[4:1];
            got.address = m_axis_tdata[36:5];
            got.last    = m_axis_tlast;
            sb.check_access(got);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] build_insn(logic p, logic u, logic s, logic w,
                                               logic l, logic [3:0] rn,
                                               logic [15:0] list, logic [6:0] hi);
        return {hi, p, u, s, w, l, rn, list};
    endfunction

    // offer one instruction and wait for its transfer
    task automatic send_insn(input logic [31:0] insn, input logic [31:0] base);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {base, insn};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_instruction(insn, base);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
    endtask

    // random register list of varied density
    function automatic logic [15:0] pick_list();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1, 2:    return 16'h1 << $urandom_range(15);
            3:       return 16'hFFFF;
            4, 5:    return 16'($urandom & $urandom & $urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    // random base, biased toward both ends of the address space
    function automatic logic [31:0] pick_base();
        case ($urandom_range(5))
            0:       return $urandom_range(63);
            1:       return 32'hFFFF_FFFF - $urandom_range(63);
            default: return $urandom;
        endcase
    endfunction

    // stimulus and end of run
    initial begin
        logic [31:0] w;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every mode, list extremes, wrap, empty list, user bank
        send_insn(build_insn(0, 1, 0, 1, 1, 4'd1, 16'h0001, 7'h00), 32'h0000_1000);
        send_insn(build_insn(1, 1, 0, 1, 1, 4'd2, 16'h8001, 7'h00), 32'h0000_2000);
        send_insn(build_insn(0, 0, 0, 1, 0, 4'd3, 16'h00F0, 7'h00), 32'h0000_3000);
        send_insn(build_insn(1, 0, 0, 1, 1, 4'd13, 16'hFFFF, 7'h00), 32'h0000_4000);
        send_insn(build_insn(0, 1, 0, 0, 0, 4'd4, 16'hFFFF, 7'h00), 32'hFFFF_FFF0);
        send_insn(build_insn(1, 0, 0, 1, 0, 4'd5, 16'h0003, 7'h00), 32'h0000_0004);
        send_insn(build_insn(1, 1, 0, 0, 0, 4'd6, 16'h0101, 7'h00), 32'hFFFF_FFFC);
        send_insn(build_insn(0, 0, 0, 0, 1, 4'd7, 16'h8000, 7'h00), 32'h0000_0000);
        send_insn(build_insn(0, 1, 0, 1, 1, 4'd8, 16'h0000, 7'h00), 32'h0000_1234);
        send_insn(build_insn(1, 0, 0, 1, 0, 4'd9, 16'h0000, 7'h00), 32'hFFFF_FFFF);
        send_insn(build_insn(1, 1, 0, 0, 1, 4'd10, 16'h0000, 7'h00), 32'h0000_5678);
        send_insn(build_insn(0, 1, 1, 0, 1, 4'd15, 16'h00FF, 7'h00), 32'h0000_9000);
        send_insn(build_insn(1, 0, 1, 1, 0, 4'd0, 16'hFFFF, 7'h00), 32'hFFFF_FFFF);
        send_insn(build_insn(1, 0, 0, 1, 1, 4'd3, 16'h0008, 7'h00), 32'h0000_0100);
        send_insn(build_insn(0, 1, 0, 1, 0, 4'd11, 16'h00AA, 7'h7F), 32'h0000_0200);
        send_insn(build_insn(0, 1, 0, 1, 1, 4'd12, 16'hFFFF, 7'h00), 32'hFFFF_FFFF);
        send_insn(build_insn(1, 0, 0, 1, 0, 4'd14, 16'hFFFF, 7'h00), 32'h0000_0000);
        send_insn(32'h0000_0000, 32'h0000_0000);
        send_insn(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_insn(build_insn(1, 1, 0, 1, 1, 4'd15, 16'h7FFE, 7'h2A), 32'h8000_0000);

        // random: mostly decodable forms, some user-bank noise
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 150)
                hold_go <= 1'b1;
            if (n == 250)
                steady <= 1'b1;
            if (n == 330)
                steady <= 1'b0;
            w = $urandom;
            w[BIT_USER] = ($urandom_range(99) < 8);
            w[15:0]     = pick_list();
            send_insn(w, pick_base());
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
